>>> rtl/core/ctwm_pkg.sv
// Shared types and codes for the classifier table.
package ctwm_pkg;
    typedef enum logic [1:0] {
        REQ_LOOKUP  = 2'd0,
        REQ_INSTALL = 2'd1,
        REQ_REMOVE  = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_SP    = 2'd1;
    localparam logic [1:0] KIND_SG    = 2'd2;

    typedef struct packed {
        t_req        req;
        logic [31:0] key;
        logic [15:0] pay;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DONE,
        S_SHIFT,
        S_WRITE,
        S_REPLY
    } t_state;
endpackage

>>> rtl/core/ctwm_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module ctwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/ctwm_front.sv
// Front end: takes requests and holds a one-deep queue.
module ctwm_front
    import ctwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_cmd        i_cmd,
    input  logic        i_take,
    output logic        o_busy,
    output logic        o_valid,
    output t_cmd        o_cmd
);
    logic r_valid;
    logic r_busy;
    t_cmd r_cmd;

    // busy until the back end has answered the queued request
    assign o_busy  = r_busy;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            if (i_start && !r_busy) begin
                r_valid <= 1'b1;
                r_busy  <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
                r_busy  <= 1'b0;
            end
        end
        if (i_start && !r_busy) begin
            r_cmd <= i_cmd;
        end
    end
endmodule

>>> rtl/core/ctwm_back.sv
// Back end: scans, edits and shifts the table, then issues one response.
module ctwm_back
    import ctwm_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_take,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [7:0]  o_match_index,
    output logic [1:0]  o_match_kind,
    output logic [15:0] o_payload_out,
    output logic [8:0]  o_entry_count
);
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;       // scan/shift position
    logic [CW-1:0] r_hit, n_hit;
    logic [CW-1:0] r_spw, n_spw;
    logic [CW-1:0] r_sgw, n_sgw;
    logic          r_rd, n_rd;         // read data for r_idx-1 valid
    logic [1:0]    r_status, n_status;
    logic [1:0]    r_kind, n_kind;
    logic [15:0]   r_pout, n_pout;
    logic [CW-1:0] r_oidx, n_oidx;
    logic          r_strobe, n_strobe;

    logic          kwe, pwe;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   kwdata, krd;
    logic [15:0]   pwdata, prd;
    logic [CW-1:0] rd_pos;
    logic [31:0]   q_sp, q_sg;

    ctwm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_key (
        .i_clk(i_clk), .i_we(kwe), .i_waddr(waddr), .i_wdata(kwdata),
        .i_raddr(raddr), .o_rdata(krd));
    ctwm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_pay (
        .i_clk(i_clk), .i_we(pwe), .i_waddr(waddr), .i_wdata(pwdata),
        .i_raddr(raddr), .o_rdata(prd));

    assign q_sp   = {i_cmd.key[31:16], 8'd0, i_cmd.key[7:0]};
    assign q_sg   = {i_cmd.key[31:24], 16'd0, i_cmd.key[7:0]};
    assign rd_pos = r_idx - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_rd     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_rd     <= n_rd;
        end
        r_idx    <= n_idx;
        r_hit    <= n_hit;
        r_spw    <= n_spw;
        r_sgw    <= n_sgw;
        r_status <= n_status;
        r_kind   <= n_kind;
        r_pout   <= n_pout;
        r_oidx   <= n_oidx;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_spw    = r_spw;
        n_sgw    = r_sgw;
        n_rd     = 1'b0;
        n_status = r_status;
        n_kind   = r_kind;
        n_pout   = r_pout;
        n_oidx   = r_oidx;
        n_strobe = 1'b0;
        o_take   = 1'b0;
        kwe      = 1'b0;
        pwe      = 1'b0;
        waddr    = r_hit[AW-1:0];
        kwdata   = i_cmd.key;
        pwdata   = i_cmd.pay;
        raddr    = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_idx    = '0;
                    n_hit    = r_count;
                    n_spw    = r_count;
                    n_sgw    = r_count;
                    n_status = ST_MISS;
                    n_kind   = KIND_EXACT;
                    n_pout   = '0;
                    n_oidx   = '0;
                    n_state  = (i_cmd.req == REQ_NONE) ? S_REPLY : S_SCAN;
                end
            end
            S_SCAN: begin
                // issue read of r_idx, compare data from r_idx-1
                if (r_rd) begin
                    if (krd == i_cmd.key) begin
                        n_hit   = rd_pos;
                        n_state = S_DONE;
                    end else begin
                        if (krd == q_sp) n_spw = rd_pos;
                        if (krd == q_sg) n_sgw = rd_pos;
                    end
                end
                if (!(r_rd && krd == i_cmd.key)) begin
                    if (r_idx < r_count) begin
                        n_idx = r_idx + CW'(1);
                        n_rd  = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                n_state = S_REPLY;
                case (i_cmd.req)
                    REQ_LOOKUP: begin
                        if (r_hit != r_count) begin
                            n_status = ST_OK; n_oidx = r_hit; n_kind = KIND_EXACT;
                        end else if (r_spw != r_count) begin
                            n_status = ST_OK; n_oidx = r_spw; n_kind = KIND_SP;
                        end else if (r_sgw != r_count) begin
                            n_status = ST_OK; n_oidx = r_sgw; n_kind = KIND_SG;
                        end
                        if (n_status == ST_OK) begin
                            n_idx   = n_oidx;
                            n_state = S_WRITE;  // fetch the payload
                        end
                    end
                    REQ_INSTALL: begin
                        if (r_hit != r_count) begin
                            pwe = 1'b1; n_status = ST_OK; n_oidx = r_hit;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            waddr = r_count[AW-1:0];
                            kwe = 1'b1; pwe = 1'b1;
                            n_status = ST_OK; n_oidx = r_count;
                            n_count = r_count + CW'(1);
                        end
                    end
                    REQ_REMOVE: begin
                        if (r_hit != r_count) begin
                            n_status = ST_OK; n_oidx = r_hit;
                            n_idx = r_hit + CW'(1);
                            n_state = S_SHIFT;
                        end
                    end
                    default: ;
                endcase
            end
            S_SHIFT: begin
                // read idx, then write idx-1 the next cycle
                if (r_rd) begin
                    waddr  = rd_pos[AW-1:0] - AW'(1);
                    kwdata = krd;
                    pwdata = prd;
                    kwe = 1'b1; pwe = 1'b1;
                end
                if (r_idx < r_count) begin
                    n_idx = r_idx + CW'(1);
                    n_rd  = 1'b1;
                end else if (!r_rd) begin
                    waddr  = AW'(r_count - CW'(1));
                    kwdata = '0;
                    pwdata = '0;
                    kwe = 1'b1; pwe = 1'b1;
                    n_count = r_count - CW'(1);
                    n_state = S_REPLY;
                end
            end
            S_WRITE: begin
                // payload read issued; data arrives next cycle
                if (r_rd) begin
                    n_pout  = prd;
                    n_state = S_REPLY;
                end else begin
                    n_rd = 1'b1;
                end
            end
            S_REPLY: begin
                n_strobe = 1'b1;
                o_take   = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_match_index = 8'(r_oidx);
    assign o_match_kind  = r_kind;
    assign o_payload_out = r_pout;
    assign o_entry_count = 9'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("count above depth");
    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_count == CW'(DEPTH)) |=> r_count == CW'(DEPTH))
        else $error("count grew when full");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_state == S_IDLE) else $error("strobe outside idle");
endmodule

>>> rtl/core/classifier_table_wildcard_match.sv
// Top level of the classifier table with wildcard lookup.
// Usage: drive i_req_type, the four key bytes and i_payload_in, and raise
// start while busy is low; the request is taken on that edge.
// Requests: lookup (exact, then last species wildcard, then last species
// and genus wildcard), install (overwrite or append) and remove (delete
// first exact match, shift later entries down, clear the freed slot).
// Each request yields exactly one response, shown for one cycle with
// o_strobe high; the receiver cannot hold it off.
// Each RAM has a single read port; the scan stops at the first exact
// hit, and remove shifts only the entries after it.
// One request is in flight at a time.
// busy stays high until the response; it drops as o_strobe rises, so the
// next request can be taken at the edge that ends the strobe cycle.
// Reset (synchronous, active low) empties the table: the entry count
// drops to zero, so no stale slot is ever read, and no clearing pass is
// needed.
module classifier_table_wildcard_match
    import ctwm_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_key_family,
    input  logic [7:0]  i_key_genus,
    input  logic [7:0]  i_key_species,
    input  logic [7:0]  i_key_event,
    input  logic [15:0] i_payload_in,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [7:0]  o_match_index,
    output logic [1:0]  o_match_kind,
    output logic [15:0] o_payload_out,
    output logic [8:0]  o_entry_count
);
    t_cmd cmd_in, cmd_q;
    logic q_valid, take;

    assign cmd_in.req = t_req'(i_req_type);
    assign cmd_in.key = {i_key_family, i_key_genus, i_key_species, i_key_event};
    assign cmd_in.pay = i_payload_in;

    ctwm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_cmd(cmd_in),
        .i_take(take), .o_busy(busy), .o_valid(q_valid), .o_cmd(cmd_q));

    ctwm_back #(.DEPTH(DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(cmd_q),
        .o_take(take), .o_strobe(o_strobe), .o_status(o_status),
        .o_match_index(o_match_index), .o_match_kind(o_match_kind),
        .o_payload_out(o_payload_out), .o_entry_count(o_entry_count));
endmodule
